FILE: rtl/core/ecfc_pkg.sv
// ============================================================================
// ecfc_pkg
// Shared types, codes and constants for the ECN fraction congestion engine.
// ============================================================================
package ecfc_pkg;

   localparam int unsigned SeqWidth   = 32;
   localparam int unsigned CwndWidth  = 20;
   localparam int unsigned AlphaWidth = 11;
   localparam int unsigned ShiftWidth = 4;
   localparam int unsigned StateWidth = 3;
   localparam int unsigned ProdWidth  = CwndWidth + AlphaWidth;

   localparam logic [AlphaWidth-1:0] ALPHA_MAX        = 11'd1024;
   localparam logic [AlphaWidth-1:0] LOW_ALPHA_LIMIT  = 11'd50;
   localparam logic [ShiftWidth-1:0] FRACTION_BITS    = 4'd10;
   localparam logic [ShiftWidth-1:0] EWMA_SHIFT_RESET = 4'd6;
   localparam logic [CwndWidth-1:0]  SSTHRESH_FLOOR   = 20'd2;
   localparam int unsigned           LightCutShift    = 4;
   localparam int unsigned           AlphaScaleBits   = 11;

   // Request codes.
   localparam logic [2:0] REQ_INIT     = 3'd0;
   localparam logic [2:0] REQ_ACK      = 3'd1;
   localparam logic [2:0] REQ_LOSS     = 3'd2;
   localparam logic [2:0] REQ_STATE    = 3'd3;
   localparam logic [2:0] REQ_SSTHRESH = 3'd4;
   localparam logic [2:0] REQ_UNDO     = 3'd5;

   // Congestion state code for recovery.
   localparam logic [StateWidth-1:0] CA_RECOVERY = 3'd3;

   // Configuration register indexes.
   localparam logic CSR_EWMA_SHIFT    = 1'b0;
   localparam logic CSR_INITIAL_ALPHA = 1'b1;

   typedef struct packed {
      logic [2:0]            req_type;
      logic [SeqWidth-1:0]   unacked_seq;
      logic [SeqWidth-1:0]   next_send_seq;
      logic [SeqWidth-1:0]   delivered_total;
      logic [SeqWidth-1:0]   delivered_marked;
      logic [CwndWidth-1:0]  cwnd_now;
      logic [StateWidth-1:0] new_ca_state;
      logic [StateWidth-1:0] cur_ca_state;
   } req_payload_type;

   typedef struct packed {
      logic [AlphaWidth-1:0] alpha_now;
      logic [CwndWidth-1:0]  ssthresh_value;
      logic                  ssthresh_valid;
      logic [CwndWidth-1:0]  undo_cwnd_value;
   } rsp_payload_type;

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_EXEC,
      ST_DIV,
      ST_DONE
   } ctrl_state_type;

   typedef struct packed {
      logic capture;
      logic div_start;
      logic commit;
   } dp_cmd_type;

   typedef struct packed {
      logic needs_div;
      logic div_busy;
      logic out_free;
   } dp_status_type;

endpackage

FILE: rtl/core/ecfc_div.sv
// ============================================================================
// ecfc_div
// Restoring divider, 32-bit unsigned, one quotient bit per cycle.
// ============================================================================
module ecfc_div (
   input  logic                           clock,
   input  logic                           reset,
   input  logic                           start,
   input  logic [ecfc_pkg::SeqWidth-1:0]  dividend,
   input  logic [ecfc_pkg::SeqWidth-1:0]  divisor,
   output logic                           busy,
   output logic [ecfc_pkg::SeqWidth-1:0]  quotient
);

   logic                          busy_ff, busy_in;
   logic [4:0]                    count_ff, count_in;
   logic [ecfc_pkg::SeqWidth-1:0] rem_ff, rem_in;
   logic [ecfc_pkg::SeqWidth-1:0] quo_ff, quo_in;
   logic [ecfc_pkg::SeqWidth-1:0] dsor_ff, dsor_in;
   logic [ecfc_pkg::SeqWidth:0]   trial;
   logic [ecfc_pkg::SeqWidth:0]   diff;

   always_comb begin
      trial    = {rem_ff, quo_ff[ecfc_pkg::SeqWidth-1]};
      diff     = trial - {1'b0, dsor_ff};
      busy_in  = busy_ff;
      count_in = count_ff;
      rem_in   = rem_ff;
      quo_in   = quo_ff;
      dsor_in  = dsor_ff;
      if (start) begin
         busy_in  = 1'b1;
         count_in = '0;
         rem_in   = '0;
         quo_in   = dividend;
         dsor_in  = divisor;
      end else if (busy_ff) begin
         // The partial remainder always stays below the divisor.
         if (!diff[ecfc_pkg::SeqWidth]) begin
            rem_in = diff[ecfc_pkg::SeqWidth-1:0];
         end else begin
            rem_in = trial[ecfc_pkg::SeqWidth-1:0];
         end
         quo_in   = {quo_ff[ecfc_pkg::SeqWidth-2:0], ~diff[ecfc_pkg::SeqWidth]};
         count_in = count_ff + 5'd1;
         if (count_ff == 5'd31) begin
            busy_in = 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff  <= 1'b0;
         count_ff <= '0;
      end else begin
         busy_ff  <= busy_in;
         count_ff <= count_in;
      end
      rem_ff  <= rem_in;
      quo_ff  <= quo_in;
      dsor_ff <= dsor_in;
   end

   assign busy     = busy_ff;
   assign quotient = quo_ff;

endmodule

FILE: rtl/core/ecfc_ctrl.sv
// ============================================================================
// ecfc_ctrl
// Sequencer: capture, evaluate, optional divide, then commit to the output.
// ============================================================================
module ecfc_ctrl (
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    req_valid,
   output logic                    req_stall,
   input  ecfc_pkg::dp_status_type sts,
   output ecfc_pkg::dp_cmd_type    cmd
);

   ecfc_pkg::ctrl_state_type state_ff, state_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ecfc_pkg::ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   always_comb begin
      state_in = state_ff;
      cmd      = '0;
      unique case (state_ff)
         ecfc_pkg::ST_IDLE: begin
            if (req_valid) begin
               cmd.capture = 1'b1;
               state_in    = ecfc_pkg::ST_EXEC;
            end
         end
         ecfc_pkg::ST_EXEC: begin
            if (sts.needs_div) begin
               cmd.div_start = 1'b1;
               state_in      = ecfc_pkg::ST_DIV;
            end else begin
               state_in = ecfc_pkg::ST_DONE;
            end
         end
         ecfc_pkg::ST_DIV: begin
            if (!sts.div_busy) begin
               state_in = ecfc_pkg::ST_DONE;
            end
         end
         ecfc_pkg::ST_DONE: begin
            if (sts.out_free) begin
               cmd.commit = 1'b1;
               state_in   = ecfc_pkg::ST_IDLE;
            end
         end
         default: begin
            state_in = ecfc_pkg::ST_IDLE;
         end
      endcase
   end

   assign req_stall = (state_ff != ecfc_pkg::ST_IDLE);

endmodule

FILE: rtl/core/ecfc_dpath.sv
// ============================================================================
// ecfc_dpath
// Datapath: configuration, flow state, item register, multiplier, divider
// and the result register.
// ============================================================================
module ecfc_dpath (
   input  logic                              clock,
   input  logic                              reset,
   input  ecfc_pkg::req_payload_type         req_payload,
   output logic                              rsp_valid,
   input  logic                              rsp_stall,
   output ecfc_pkg::rsp_payload_type         rsp_payload,
   input  logic                              csr_wr_en,
   input  logic                              csr_index,
   input  logic [ecfc_pkg::AlphaWidth-1:0]   csr_wdata,
   input  ecfc_pkg::dp_cmd_type              cmd,
   output ecfc_pkg::dp_status_type           sts
);

   localparam int unsigned SW = ecfc_pkg::SeqWidth;
   localparam int unsigned CW = ecfc_pkg::CwndWidth;
   localparam int unsigned AW = ecfc_pkg::AlphaWidth;

   logic [ecfc_pkg::ShiftWidth-1:0] ewma_shift_ff;
   logic [AW-1:0]                   initial_alpha_ff;

   logic [AW-1:0]                   alpha_ff, alpha_in;
   logic [SW-1:0]                   window_end_ff, window_end_in;
   logic [SW-1:0]                   dlv_snap_ff, dlv_snap_in;
   logic [SW-1:0]                   mrk_snap_ff, mrk_snap_in;
   logic [CW-1:0]                   saved_cwnd_ff, saved_cwnd_in;

   ecfc_pkg::req_payload_type       item_ff;
   logic [ecfc_pkg::ProdWidth-1:0]  product_ff;

   logic                            rsp_valid_ff, rsp_valid_in;
   ecfc_pkg::rsp_payload_type       rsp_data_ff, rsp_data_in;

   logic [ecfc_pkg::ShiftWidth-1:0] gain;
   logic [ecfc_pkg::ShiftWidth-1:0] frac_shift;
   logic [SW-1:0]                   seq_diff;
   logic                            in_window;
   logic [SW-1:0]                   marked_diff;
   logic [SW-1:0]                   deliv_diff;
   logic [SW-1:0]                   dividend;
   logic [SW-1:0]                   divisor;
   logic                            div_busy;
   logic [SW-1:0]                   quotient;
   logic [AW-1:0]                   decay;
   logic [AW-1:0]                   alpha_decayed;
   logic [SW:0]                     alpha_sum;
   logic [AW-1:0]                   alpha_ack;
   logic [AW-1:0]                   alpha_init;
   logic [CW-1:0]                   dctcp_raw;
   logic [CW-1:0]                   light_raw;
   logic [CW-1:0]                   dctcp_cut;
   logic [CW-1:0]                   loss_cut;
   logic [CW-1:0]                   undo_val;

   // Gain exponent above ten behaves as ten.
   assign gain       = (ewma_shift_ff > ecfc_pkg::FRACTION_BITS) ?
                       ecfc_pkg::FRACTION_BITS : ewma_shift_ff;
   assign frac_shift = ecfc_pkg::FRACTION_BITS - gain;

   // Window check with 32-bit wraparound.
   assign seq_diff    = item_ff.unacked_seq - window_end_ff;
   assign in_window   = !seq_diff[SW-1];
   assign marked_diff = item_ff.delivered_marked - mrk_snap_ff;
   assign deliv_diff  = item_ff.delivered_total - dlv_snap_ff;
   assign dividend    = marked_diff << frac_shift;
   assign divisor     = (deliv_diff == '0) ? {{(SW-1){1'b0}}, 1'b1} : deliv_diff;

   ecfc_div u_div (
      .clock    (clock),
      .reset    (reset),
      .start    (cmd.div_start),
      .dividend (dividend),
      .divisor  (divisor),
      .busy     (div_busy),
      .quotient (quotient)
   );

   always_comb begin
      // Alpha decay; a decrement that rounds to zero empties alpha.
      decay         = alpha_ff >> gain;
      alpha_decayed = (decay == '0) ? '0 : (alpha_ff - decay);
      alpha_sum     = {{(SW+1-AW){1'b0}}, alpha_decayed} + {1'b0, quotient};
      if (marked_diff == '0) begin
         alpha_ack = alpha_decayed;
      end else if (alpha_sum > {{(SW+1-AW){1'b0}}, ecfc_pkg::ALPHA_MAX}) begin
         alpha_ack = ecfc_pkg::ALPHA_MAX;
      end else begin
         alpha_ack = alpha_sum[AW-1:0];
      end

      alpha_init = (initial_alpha_ff > ecfc_pkg::ALPHA_MAX) ?
                   ecfc_pkg::ALPHA_MAX : initial_alpha_ff;

      // The reduction is below cwnd, so neither subtraction can wrap.
      dctcp_raw = item_ff.cwnd_now -
                  product_ff[ecfc_pkg::AlphaScaleBits +: CW];
      light_raw = item_ff.cwnd_now - (item_ff.cwnd_now >> ecfc_pkg::LightCutShift);
      dctcp_cut = (dctcp_raw < ecfc_pkg::SSTHRESH_FLOOR) ?
                  ecfc_pkg::SSTHRESH_FLOOR : dctcp_raw;
      if (alpha_ff < ecfc_pkg::LOW_ALPHA_LIMIT) begin
         loss_cut = (light_raw < ecfc_pkg::SSTHRESH_FLOOR) ?
                    ecfc_pkg::SSTHRESH_FLOOR : light_raw;
      end else begin
         loss_cut = dctcp_cut;
      end
      undo_val = (item_ff.cwnd_now > saved_cwnd_ff) ? item_ff.cwnd_now : saved_cwnd_ff;
   end

   always_comb begin
      alpha_in      = alpha_ff;
      window_end_in = window_end_ff;
      dlv_snap_in   = dlv_snap_ff;
      mrk_snap_in   = mrk_snap_ff;
      saved_cwnd_in = saved_cwnd_ff;
      rsp_data_in   = rsp_data_ff;
      rsp_valid_in  = rsp_valid_ff && rsp_stall;
      if (cmd.commit) begin
         rsp_valid_in                = 1'b1;
         rsp_data_in.ssthresh_value  = '0;
         rsp_data_in.ssthresh_valid  = 1'b0;
         rsp_data_in.undo_cwnd_value = '0;
         case (item_ff.req_type)
            ecfc_pkg::REQ_INIT: begin
               alpha_in      = alpha_init;
               saved_cwnd_in = '0;
               window_end_in = item_ff.next_send_seq;
               dlv_snap_in   = item_ff.delivered_total;
               mrk_snap_in   = item_ff.delivered_marked;
            end
            ecfc_pkg::REQ_ACK: begin
               if (in_window) begin
                  alpha_in      = alpha_ack;
                  window_end_in = item_ff.next_send_seq;
                  dlv_snap_in   = item_ff.delivered_total;
                  mrk_snap_in   = item_ff.delivered_marked;
               end
            end
            ecfc_pkg::REQ_LOSS: begin
               saved_cwnd_in              = item_ff.cwnd_now;
               rsp_data_in.ssthresh_value = loss_cut;
               rsp_data_in.ssthresh_valid = 1'b1;
            end
            ecfc_pkg::REQ_STATE: begin
               if ((item_ff.new_ca_state == ecfc_pkg::CA_RECOVERY) &&
                   (item_ff.cur_ca_state != ecfc_pkg::CA_RECOVERY)) begin
                  saved_cwnd_in              = item_ff.cwnd_now;
                  rsp_data_in.ssthresh_value = loss_cut;
                  rsp_data_in.ssthresh_valid = 1'b1;
               end
            end
            ecfc_pkg::REQ_SSTHRESH: begin
               saved_cwnd_in              = item_ff.cwnd_now;
               rsp_data_in.ssthresh_value = dctcp_cut;
               rsp_data_in.ssthresh_valid = 1'b1;
            end
            ecfc_pkg::REQ_UNDO: begin
               rsp_data_in.undo_cwnd_value = undo_val;
            end
            default: begin
            end
         endcase
         rsp_data_in.alpha_now = alpha_in;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         ewma_shift_ff    <= ecfc_pkg::EWMA_SHIFT_RESET;
         initial_alpha_ff <= ecfc_pkg::ALPHA_MAX;
         alpha_ff         <= ecfc_pkg::ALPHA_MAX;
         window_end_ff    <= '0;
         dlv_snap_ff      <= '0;
         mrk_snap_ff      <= '0;
         saved_cwnd_ff    <= '0;
         rsp_valid_ff     <= 1'b0;
      end else begin
         if (csr_wr_en) begin
            unique case (csr_index)
               ecfc_pkg::CSR_EWMA_SHIFT: begin
                  ewma_shift_ff <= csr_wdata[ecfc_pkg::ShiftWidth-1:0];
               end
               ecfc_pkg::CSR_INITIAL_ALPHA: begin
                  initial_alpha_ff <= csr_wdata;
               end
               default: begin
               end
            endcase
         end
         alpha_ff      <= alpha_in;
         window_end_ff <= window_end_in;
         dlv_snap_ff   <= dlv_snap_in;
         mrk_snap_ff   <= mrk_snap_in;
         saved_cwnd_ff <= saved_cwnd_in;
         rsp_valid_ff  <= rsp_valid_in;
      end
      if (cmd.capture) begin
         item_ff <= req_payload;
      end
      product_ff  <= item_ff.cwnd_now * alpha_ff;
      rsp_data_ff <= rsp_data_in;
   end

   assign sts.needs_div = (item_ff.req_type == ecfc_pkg::REQ_ACK) && in_window &&
                          (marked_diff != '0);
   assign sts.div_busy  = div_busy;
   assign sts.out_free  = !rsp_valid_ff || !rsp_stall;

   assign rsp_valid   = rsp_valid_ff;
   assign rsp_payload = rsp_data_ff;

endmodule

FILE: rtl/core/ecn_fraction_congestion_control_unit.sv
// ============================================================================
// ecn_fraction_congestion_control_unit
// Per-flow ECN fraction congestion engine: alpha estimator, ssthresh cut on loss,
// recovery entry or an ssthresh request, and undo window.
// ============================================================================
//
//   Channel   Direction  Handshake             Beat contents
//   req_      in         req_valid/req_stall   one event (req_payload_type)
//   rsp_      out        rsp_valid/rsp_stall   one result (rsp_payload_type)
//   csr_      in         csr_wr_en             register write, no read-back
//
// One event is handled at a time. An ACK that closes the observation window
// with new marks also passes through the 32-step serial divider for the
// marked fraction; every other event goes from evaluation straight to commit.
// Reset is synchronous and active high; it clears the flow state and loads
// alpha with 1024, the gain exponent with 6 and the initial alpha with 1024.
// A finished result sits in an output register, so a new beat is taken while
// rsp_stall holds the previous one; the engine only waits before its commit
// step when that register is still full and rsp_stall is high.
//
module ecn_fraction_congestion_control_unit (
   input  logic                             clock,
   input  logic                             reset,
   input  logic                             req_valid,
   output logic                             req_stall,
   input  ecfc_pkg::req_payload_type        req_payload,
   output logic                             rsp_valid,
   input  logic                             rsp_stall,
   output ecfc_pkg::rsp_payload_type        rsp_payload,
   input  logic                             csr_wr_en,
   input  logic                             csr_index,
   input  logic [ecfc_pkg::AlphaWidth-1:0]  csr_wdata
);

   // Command and status between the sequencer and the datapath.
   ecfc_pkg::dp_cmd_type    cmd;
   ecfc_pkg::dp_status_type sts;

   // The sequencer owns the handshake on the request side; it steps each
   // event through capture, evaluation, an optional division and commit.
   ecfc_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .sts       (sts),
      .cmd       (cmd)
   );

   // The datapath holds configuration, flow state, the captured event, the
   // cwnd-by-alpha product, the divider and the result register.
   ecfc_dpath u_dpath (
      .clock       (clock),
      .reset       (reset),
      .req_payload (req_payload),
      .rsp_valid   (rsp_valid),
      .rsp_stall   (rsp_stall),
      .rsp_payload (rsp_payload),
      .csr_wr_en   (csr_wr_en),
      .csr_index   (csr_index),
      .csr_wdata   (csr_wdata),
      .cmd         (cmd),
      .sts         (sts)
   );

endmodule
